FILE: src/nearest_neighbor_tile_scaler_top_macros.svh
`ifndef NEAREST_NEIGHBOR_TILE_SCALER_TOP_MACROS_SVH
`define NEAREST_NEIGHBOR_TILE_SCALER_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define NNTS_AST_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scaler port check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define NNTS_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scaler port check failed");

`endif

FILE: src/nnts_pkg.sv
package nnts_pkg;

	localparam int TILE_WORDS   = 4096;
	localparam int TILE_AW      = $clog2(TILE_WORDS);
	localparam int MAX_SCREEN_W = 800;
	localparam int MAX_SCREEN_H = 600;

	localparam int DIM_W     = 10;
	localparam int TDIM_W    = 7;
	localparam int POS_W     = DIM_W + 1;
	localparam int FB_W      = 19;
	localparam int PIX_W     = 32;
	localparam int CFG_IDX_W = 4;
	localparam int PROD_W    = DIM_W + TDIM_W;
	localparam int FBP_W     = POS_W + DIM_W;
	localparam int SRC_W     = 2 * TDIM_W;
	localparam int SUM_W     = (SRC_W > TILE_AW) ? SRC_W : TILE_AW;
	localparam int DIV_CNT_W = $clog2(TDIM_W);

	localparam logic [DIM_W-1:0]  RST_SCREEN_W = DIM_W'(400);
	localparam logic [DIM_W-1:0]  RST_SCREEN_H = DIM_W'(300);
	localparam logic [TDIM_W-1:0] RST_TILE_DIM = TDIM_W'(1);

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_DEST_X   = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_DEST_Y   = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_DEST_W   = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_DEST_H   = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_TILE_W   = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_TILE_H   = CFG_IDX_W'(7);

	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_DRAW = 1'b1;

	typedef struct packed {
		logic load_wr;
		logic draw_start;
		logic mul_en;
		logic div_start;
		logic div_sel_y;
		logic cap_sx;
		logic cap_sy;
		logic addr_en;
		logic mem_rd;
		logic out_load;
	} nnts_cmd_t;

	typedef struct packed {
		logic draw_empty;
		logic div_done;
	} nnts_sts_t;

endpackage

FILE: src/nnts_div.sv
module nnts_div import nnts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [PROD_W-1:0] dividend,
	input  logic [DIM_W-1:0]  divisor,
	output logic              done,
	output logic [TDIM_W-1:0] quotient
);

	// The quotient is known to fit in TDIM_W bits, so the upper dividend bits
	// seed the partial remainder and only TDIM_W restoring steps are needed.
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(TDIM_W - 1);

	logic [DIM_W-1:0]     rem_q;
	logic [TDIM_W-1:0]    dvd_q;
	logic [DIM_W-1:0]     dsr_q;
	logic [TDIM_W-1:0]    quo_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;

	logic [DIM_W:0]   trial;
	logic [DIM_W:0]   diff;
	logic             ge;
	logic [DIM_W-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, dvd_q[TDIM_W-1]};
		ge      = trial >= {1'b0, dsr_q};
		diff    = trial - {1'b0, dsr_q};
		rem_nxt = ge ? diff[DIM_W-1:0] : trial[DIM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == DIV_LAST);
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[PROD_W-1:TDIM_W];
			dvd_q <= dividend[TDIM_W-1:0];
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			dvd_q <= dvd_q << 1;
			quo_q <= {quo_q[TDIM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: src/nnts_datapath.sv
module nnts_datapath import nnts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data,
	input  logic [TILE_AW-1:0]   tile_index,
	input  logic [PIX_W-1:0]     pixel_in,
	input  nnts_cmd_t            cmd,
	output nnts_sts_t            sts,
	output logic [FB_W-1:0]      fb_index,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 beyond_frame,
	output logic                 last
);

	logic [DIM_W-1:0]  scr_w_q;
	logic [DIM_W-1:0]  scr_h_q;
	logic [DIM_W-1:0]  dst_x_q;
	logic [DIM_W-1:0]  dst_y_q;
	logic [DIM_W-1:0]  dst_w_q;
	logic [DIM_W-1:0]  dst_h_q;
	logic [TDIM_W-1:0] til_w_q;
	logic [TDIM_W-1:0] til_h_q;
	logic [DIM_W-1:0]  col_q;
	logic [DIM_W-1:0]  row_q;

	logic [DIM_W-1:0]  col_w_q;
	logic [DIM_W-1:0]  row_w_q;
	logic [POS_W-1:0]  fx_q;
	logic [POS_W-1:0]  fy_q;
	logic              last_q;
	logic [PROD_W-1:0] prodx_q;
	logic [PROD_W-1:0] prody_q;
	logic [FBP_W-1:0]  fbp_q;
	logic              beyond_q;
	logic [TDIM_W-1:0] sx_q;
	logic [TDIM_W-1:0] sy_q;
	logic [TILE_AW-1:0] src_q;
	logic [FB_W-1:0]   fb_q;
	logic [PIX_W-1:0]  rdata_q;
	logic [FB_W-1:0]   fb_index_q;
	logic [PIX_W-1:0]  pixel_out_q;
	logic              beyond_frame_q;
	logic              last_out_q;

	logic [PIX_W-1:0] mem [TILE_WORDS];

	logic              restart;
	logic [DIM_W-1:0]  col_eff;
	logic [DIM_W-1:0]  row_eff;
	logic [POS_W-1:0]  col_inc;
	logic [POS_W-1:0]  row_inc;
	logic [DIM_W-1:0]  col_nxt;
	logic [DIM_W-1:0]  row_nxt;
	logic              last_nxt;
	logic [DIM_W-1:0]  lim_w;
	logic [DIM_W-1:0]  lim_h;
	logic [PROD_W-1:0] div_dividend;
	logic [DIM_W-1:0]  div_divisor;
	logic              div_done;
	logic [TDIM_W-1:0] div_quo;
	logic [SUM_W-1:0]  src_sum;
	logic [FBP_W-1:0]  fb_sum;

	always_comb begin
		restart  = (col_q >= dst_w_q) || (row_q >= dst_h_q);
		col_eff  = restart ? '0 : col_q;
		row_eff  = restart ? '0 : row_q;
		col_inc  = {1'b0, col_eff} + 1'b1;
		row_inc  = {1'b0, row_eff} + 1'b1;
		col_nxt  = col_inc[DIM_W-1:0];
		row_nxt  = row_eff;
		last_nxt = 1'b0;
		if (col_inc >= {1'b0, dst_w_q}) begin
			col_nxt = '0;
			row_nxt = row_inc[DIM_W-1:0];
			if (row_inc >= {1'b0, dst_h_q}) begin
				row_nxt  = '0;
				last_nxt = 1'b1;
			end
		end
		lim_w = (scr_w_q < DIM_W'(MAX_SCREEN_W)) ? scr_w_q : DIM_W'(MAX_SCREEN_W);
		lim_h = (scr_h_q < DIM_W'(MAX_SCREEN_H)) ? scr_h_q : DIM_W'(MAX_SCREEN_H);
		div_dividend = cmd.div_sel_y ? prody_q : prodx_q;
		div_divisor  = cmd.div_sel_y ? dst_h_q : dst_w_q;
		src_sum = SUM_W'(sy_q) * SUM_W'(til_w_q) + SUM_W'(sx_q);
		fb_sum  = fbp_q + FBP_W'(fx_q);
	end

	assign sts.draw_empty = (dst_w_q == '0) || (dst_h_q == '0);
	assign sts.div_done   = div_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scr_w_q <= RST_SCREEN_W;
			scr_h_q <= RST_SCREEN_H;
			dst_x_q <= '0;
			dst_y_q <= '0;
			dst_w_q <= '0;
			dst_h_q <= '0;
			til_w_q <= RST_TILE_DIM;
			til_h_q <= RST_TILE_DIM;
			col_q   <= '0;
			row_q   <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCREEN_W: scr_w_q <= cfg_data;
					REG_SCREEN_H: scr_h_q <= cfg_data;
					REG_DEST_X:   dst_x_q <= cfg_data;
					REG_DEST_Y:   dst_y_q <= cfg_data;
					REG_DEST_W:   dst_w_q <= cfg_data;
					REG_DEST_H:   dst_h_q <= cfg_data;
					REG_TILE_W:   til_w_q <= cfg_data[TDIM_W-1:0];
					REG_TILE_H:   til_h_q <= cfg_data[TDIM_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.draw_start) begin
				col_q <= col_nxt;
				row_q <= row_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.draw_start) begin
			col_w_q <= col_eff;
			row_w_q <= row_eff;
			fx_q    <= {1'b0, dst_x_q} + {1'b0, col_eff};
			fy_q    <= {1'b0, dst_y_q} + {1'b0, row_eff};
			last_q  <= last_nxt;
		end
		if (cmd.mul_en) begin
			prodx_q  <= PROD_W'(col_w_q) * PROD_W'(til_w_q);
			prody_q  <= PROD_W'(row_w_q) * PROD_W'(til_h_q);
			fbp_q    <= FBP_W'(fy_q) * FBP_W'(scr_w_q);
			beyond_q <= (fx_q >= {1'b0, lim_w}) || (fy_q >= {1'b0, lim_h});
		end
		if (cmd.cap_sx) begin
			sx_q <= div_quo;
		end
		if (cmd.cap_sy) begin
			sy_q <= div_quo;
		end
		if (cmd.addr_en) begin
			src_q <= src_sum[TILE_AW-1:0];
			fb_q  <= beyond_q ? '0 : fb_sum[FB_W-1:0];
		end
		if (cmd.out_load) begin
			fb_index_q     <= fb_q;
			pixel_out_q    <= rdata_q;
			beyond_frame_q <= beyond_q;
			last_out_q     <= last_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_wr) begin
			mem[tile_index] <= pixel_in;
		end
		if (cmd.mem_rd) begin
			rdata_q <= mem[src_q];
		end
	end

	nnts_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign fb_index     = fb_index_q;
	assign pixel_out    = pixel_out_q;
	assign beyond_frame = beyond_frame_q;
	assign last         = last_out_q;

endmodule

FILE: src/nnts_ctrl.sv
module nnts_ctrl import nnts_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      operation,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  nnts_sts_t sts,
	output nnts_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_STARTX,
		ST_DIVX,
		ST_DIVY,
		ST_ADDR,
		ST_READ,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		accept         = in_valid && in_ready;
		cmd.load_wr    = accept && (operation == OP_LOAD);
		cmd.draw_start = accept && (operation == OP_DRAW) && !sts.draw_empty;
		cmd.mul_en     = (state_q == ST_MUL);
		cmd.div_start  = (state_q == ST_STARTX) || ((state_q == ST_DIVX) && sts.div_done);
		cmd.div_sel_y  = (state_q == ST_DIVX);
		cmd.cap_sx     = (state_q == ST_DIVX) && sts.div_done;
		cmd.cap_sy     = (state_q == ST_DIVY) && sts.div_done;
		cmd.addr_en    = (state_q == ST_ADDR);
		cmd.mem_rd     = (state_q == ST_READ);
		cmd.out_load   = (state_q == ST_FIN) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (cmd.draw_start) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:    state_q <= ST_STARTX;
				ST_STARTX: state_q <= ST_DIVX;
				ST_DIVX: begin
					if (sts.div_done) begin
						state_q <= ST_DIVY;
					end
				end
				ST_DIVY: begin
					if (sts.div_done) begin
						state_q <= ST_ADDR;
					end
				end
				ST_ADDR: state_q <= ST_READ;
				ST_READ: state_q <= ST_FIN;
				ST_FIN: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: src/nearest_neighbor_tile_scaler_top.sv
// Nearest-neighbor scaling blit engine. A load word (operation 0) writes one 32-bit
// pixel into the 4096-word tile store. A draw word (operation 1) yields the next
// pixel of the destination rectangle in raster order, fetched from the tile at
// (col*tile_w/dest_w, row*tile_h/dest_h); its column quotient and then its row
// quotient come from one shared serial divider, and one word is in flight at a time.
// A draw word with an empty rectangle yields no result word. A finished result
// waits in an output register, so input is taken again before it is collected.
// The tile store has no reset; every entry must be loaded before a draw reads it.
// Configuration writes are always ready and must only be made while idle.
module nearest_neighbor_tile_scaler_top import nnts_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [TILE_AW-1:0]   tile_index,
	input  logic [PIX_W-1:0]     pixel_in,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [FB_W-1:0]      fb_index,
	output logic [PIX_W-1:0]     pixel_out,
	output logic                 beyond_frame,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [DIM_W-1:0]     cfg_data
);

	nnts_cmd_t cmd;
	nnts_sts_t sts;

	assign cfg_ready = 1'b1;

	nnts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	nnts_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.tile_index   (tile_index),
		.pixel_in     (pixel_in),
		.cmd          (cmd),
		.sts          (sts),
		.fb_index     (fb_index),
		.pixel_out    (pixel_out),
		.beyond_frame (beyond_frame),
		.last         (last)
	);

endmodule

FILE: src/nnts_checker.sv
`include "nearest_neighbor_tile_scaler_top_macros.svh"

module nnts_checker import nnts_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               operation,
	input logic               out_valid,
	input logic               out_ready,
	input logic [FB_W-1:0]    fb_index,
	input logic [PIX_W-1:0]   pixel_out,
	input logic               beyond_frame,
	input logic               last
);

	// A result word that is not taken keeps its whole payload.
	`NNTS_AST_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fb_index) && $stable(pixel_out) && $stable(beyond_frame) && $stable(last))

	// Pixels outside the frame always report index zero.
	`NNTS_AST_IMP(a_beyond_zero, out_valid && beyond_frame, fb_index == '0)

	// No result can appear in the cycle right after a word is taken.
	`NNTS_AST_NXT(a_no_instant, in_valid && in_ready, !$rose(out_valid))

	// A tile load finishes at once and leaves the input side open.
	`NNTS_AST_NXT(a_load_ready, in_valid && in_ready && (operation == OP_LOAD), in_ready)

endmodule

bind nearest_neighbor_tile_scaler_top nnts_checker u_nnts_checker (.*);

FILE: tb/sv/nearest_neighbor_tile_scaler_top_tb.sv
`timescale 1ns / 1ps

module nearest_neighbor_tile_scaler_top_tb;
	import nnts_pkg::*;

	localparam int DRAIN_CYCLES = 40;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED_FIRST = REG_TILE_H + 1'b1;
	localparam int REG_SPACE = 2 ** CFG_IDX_W;
	localparam int DIM_MAX = 2 ** DIM_W - 1;

	typedef struct packed {
		logic [FB_W-1:0]  fb;
		logic [PIX_W-1:0] pix;
		logic             beyond;
		logic             last_px;
	} pixel_word_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 operation = OP_LOAD;
	logic [TILE_AW-1:0]   tile_index = '0;
	logic [PIX_W-1:0]     pixel_in = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [FB_W-1:0]      fb_index;
	logic [PIX_W-1:0]     pixel_out;
	logic                 beyond_frame;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_SCREEN_W;
	logic [DIM_W-1:0]     cfg_data = '0;

	int sender_idle_pct = 16;
	int recv_idle_pct = 74;
	int failures = 0;
	int counted_words = 0;

	logic [DIM_W-1:0]  blit_screen_w = RST_SCREEN_W;
	logic [DIM_W-1:0]  blit_screen_h = RST_SCREEN_H;
	logic [DIM_W-1:0]  blit_dest_x = '0;
	logic [DIM_W-1:0]  blit_dest_y = '0;
	logic [DIM_W-1:0]  blit_dest_w = '0;
	logic [DIM_W-1:0]  blit_dest_h = '0;
	logic [TDIM_W-1:0] blit_tile_w = RST_TILE_DIM;
	logic [TDIM_W-1:0] blit_tile_h = RST_TILE_DIM;
	logic [DIM_W-1:0]  blit_col = '0;
	logic [DIM_W-1:0]  blit_row = '0;

	logic [PIX_W-1:0] tile_copy [TILE_WORDS];
	bit               tile_loaded [TILE_WORDS];
	pixel_word_t      pending_pixels [$];

	nearest_neighbor_tile_scaler_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.tile_index   (tile_index),
		.pixel_in     (pixel_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.fb_index     (fb_index),
		.pixel_out    (pixel_out),
		.beyond_frame (beyond_frame),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic [TILE_AW-1:0] tile_source(int unsigned col, int unsigned row);
		int unsigned sx;
		int unsigned sy;
		sx = (col * blit_tile_w) / blit_dest_w;
		sy = (row * blit_tile_h) / blit_dest_h;
		return TILE_AW'((sy * blit_tile_w + sx) % TILE_WORDS);
	endfunction

	function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		case (idx)
			REG_SCREEN_W: blit_screen_w = data;
			REG_SCREEN_H: blit_screen_h = data;
			REG_DEST_X:   blit_dest_x = data;
			REG_DEST_Y:   blit_dest_y = data;
			REG_DEST_W:   blit_dest_w = data;
			REG_DEST_H:   blit_dest_h = data;
			REG_TILE_W:   blit_tile_w = data[TDIM_W-1:0];
			REG_TILE_H:   blit_tile_h = data[TDIM_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void predict_pixel();
		int unsigned col;
		int unsigned row;
		int unsigned fx;
		int unsigned fy;
		int unsigned lim_w;
		int unsigned lim_h;
		pixel_word_t w;
		if (blit_dest_w == 0 || blit_dest_h == 0) return;
		if (blit_col >= blit_dest_w || blit_row >= blit_dest_h) begin
			blit_col = '0;
			blit_row = '0;
		end
		col = blit_col;
		row = blit_row;
		fx = blit_dest_x + col;
		fy = blit_dest_y + row;
		lim_w = (blit_screen_w < MAX_SCREEN_W) ? blit_screen_w : MAX_SCREEN_W;
		lim_h = (blit_screen_h < MAX_SCREEN_H) ? blit_screen_h : MAX_SCREEN_H;
		w.beyond = (fx >= lim_w) || (fy >= lim_h);
		w.fb = w.beyond ? '0 : FB_W'(fy * blit_screen_w + fx);
		w.pix = tile_copy[tile_source(col, row)];
		w.last_px = 1'b0;
		if (col + 1 >= blit_dest_w) begin
			blit_col = '0;
			if (row + 1 >= blit_dest_h) begin
				blit_row = '0;
				w.last_px = 1'b1;
			end else begin
				blit_row = DIM_W'(row + 1);
			end
		end else begin
			blit_col = DIM_W'(col + 1);
		end
		pending_pixels.push_back(w);
	endfunction

	always @(posedge clk) begin
		pixel_word_t w;
		if (arst_n && out_valid && out_ready) begin
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel word, fb_index %0d pixel %h",
					$time, fb_index, pixel_out);
				failures++;
			end else begin
				w = pending_pixels.pop_front();
				if (fb_index !== w.fb) begin
					$display("%0t: fb_index expected %0d actual %0d", $time, w.fb, fb_index);
					failures++;
				end
				if (pixel_out !== w.pix) begin
					$display("%0t: pixel_out expected %h actual %h", $time, w.pix, pixel_out);
					failures++;
				end
				if (beyond_frame !== w.beyond) begin
					$display("%0t: beyond_frame expected %b actual %b",
						$time, w.beyond, beyond_frame);
					failures++;
				end
				if (last !== w.last_px) begin
					$display("%0t: last expected %b actual %b", $time, w.last_px, last);
					failures++;
				end
			end
		end
		out_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	task automatic issue_word(logic op, logic [TILE_AW-1:0] idx, logic [PIX_W-1:0] pix);
		int gap;
		gap = 0;
		while ($urandom_range(99) < sender_idle_pct) gap++;
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		tile_index <= idx;
		pixel_in <= pix;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op == OP_LOAD) begin
			tile_copy[idx] = pix;
			tile_loaded[idx] = 1'b1;
		end else if (blit_dest_w != 0 && blit_dest_h != 0) begin
			predict_pixel();
		end
		counted_words++;
	endtask

	// A draw never reads a tile entry that was not loaded: load it first.
	task automatic request_pixel();
		int unsigned col;
		int unsigned row;
		logic [TILE_AW-1:0] src;
		if (blit_dest_w != 0 && blit_dest_h != 0) begin
			col = (blit_col >= blit_dest_w || blit_row >= blit_dest_h) ? 0 : blit_col;
			row = (blit_col >= blit_dest_w || blit_row >= blit_dest_h) ? 0 : blit_row;
			src = tile_source(col, row);
			if (!tile_loaded[src]) issue_word(OP_LOAD, src, $urandom());
		end
		issue_word(OP_DRAW, TILE_AW'($urandom()), $urandom());
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_rectangle(int x, int y, int w, int h);
		write_reg(REG_DEST_X, DIM_W'(x));
		write_reg(REG_DEST_Y, DIM_W'(y));
		write_reg(REG_DEST_W, DIM_W'(w));
		write_reg(REG_DEST_H, DIM_W'(h));
	endtask

	task automatic test_empty_rectangle();
		request_pixel();
		drain();
		write_reg(REG_DEST_W, DIM_W'(3));
		request_pixel();
	endtask

	task automatic test_load_extremes();
		drain();
		write_reg(REG_DEST_H, DIM_W'(1));
		issue_word(OP_LOAD, '0, '1);
		issue_word(OP_LOAD, '1, '0);
		issue_word(OP_LOAD, TILE_AW'('hAAA), 32'h5555_5555);
		request_pixel();
		issue_word(OP_LOAD, '0, '0);
		request_pixel();
	endtask

	task automatic test_raster_order();
		drain();
		set_rectangle(5, 7, 2, 2);
		write_reg(REG_TILE_W, DIM_W'(4));
		write_reg(REG_TILE_H, DIM_W'(5));
		repeat (5) request_pixel();
	endtask

	task automatic test_frame_edges();
		drain();
		write_reg(REG_SCREEN_W, DIM_W'(MAX_SCREEN_W));
		write_reg(REG_SCREEN_H, DIM_W'(MAX_SCREEN_H));
		set_rectangle(MAX_SCREEN_W - 1, MAX_SCREEN_H - 1, 2, 2);
		repeat (4) request_pixel();
		drain();
		write_reg(REG_SCREEN_W, '0);
		request_pixel();
	endtask

	task automatic test_rectangle_shrink();
		drain();
		write_reg(REG_SCREEN_W, '1);
		write_reg(REG_SCREEN_H, '1);
		set_rectangle(0, 0, 3, 3);
		repeat (4) request_pixel();
		drain();
		write_reg(REG_DEST_W, DIM_W'(1));
		request_pixel();
	endtask

	task automatic test_register_masking();
		drain();
		write_reg(REG_TILE_W, '1);
		write_reg(REG_TILE_H, '1);
		for (int i = REG_UNUSED_FIRST; i < REG_SPACE; i++) write_reg(CFG_IDX_W'(i), '1);
		set_rectangle(1, 1, 2, 2);
		repeat (4) request_pixel();
	endtask

	task automatic test_largest_rectangle();
		drain();
		write_reg(REG_SCREEN_W, DIM_W'(MAX_SCREEN_W));
		write_reg(REG_SCREEN_H, DIM_W'(MAX_SCREEN_H));
		write_reg(REG_TILE_W, DIM_W'(64));
		write_reg(REG_TILE_H, DIM_W'(64));
		set_rectangle(0, 0, MAX_SCREEN_W, MAX_SCREEN_H);
		repeat (2) request_pixel();
	endtask

	function automatic logic [DIM_W-1:0] pick_dim(int lo, int hi);
		case ($urandom_range(9))
			0: return DIM_W'(lo);
			1: return DIM_W'(hi);
			2: return DIM_W'($urandom_range(DIM_MAX));
			default: return DIM_W'($urandom_range(hi, lo));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_extent(int hi);
		case ($urandom_range(9))
			0: return '0;
			1: return DIM_W'(hi);
			2: return DIM_W'($urandom_range(DIM_MAX));
			default: return DIM_W'($urandom_range(6, 1));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] pick_tile();
		case ($urandom_range(9))
			0: return DIM_W'(1);
			1: return DIM_W'(64);
			2: return DIM_W'($urandom_range(DIM_MAX));
			default: return DIM_W'($urandom_range(8, 1));
		endcase
	endfunction

	task automatic random_blit_phase();
		int loads;
		int draws;
		drain();
		if ($urandom_range(1)) write_reg(REG_SCREEN_W, pick_dim(1, MAX_SCREEN_W));
		if ($urandom_range(1)) write_reg(REG_SCREEN_H, pick_dim(1, MAX_SCREEN_H));
		if ($urandom_range(1)) write_reg(REG_DEST_X, pick_dim(0, MAX_SCREEN_W - 1));
		if ($urandom_range(1)) write_reg(REG_DEST_Y, pick_dim(0, MAX_SCREEN_H - 1));
		if ($urandom_range(1)) write_reg(REG_DEST_W, pick_extent(MAX_SCREEN_W));
		if ($urandom_range(1)) write_reg(REG_DEST_H, pick_extent(MAX_SCREEN_H));
		if ($urandom_range(1)) write_reg(REG_TILE_W, pick_tile());
		if ($urandom_range(1)) write_reg(REG_TILE_H, pick_tile());
		loads = $urandom_range(3);
		draws = $urandom_range(20, 1);
		repeat (loads) issue_word(OP_LOAD, TILE_AW'($urandom()), $urandom());
		repeat (draws) request_pixel();
	endtask

	task automatic test_random_blits(int sender_pct, int recv_pct, int goal);
		int target;
		target = counted_words + goal;
		drain();
		sender_idle_pct = sender_pct;
		recv_idle_pct = recv_pct;
		while (counted_words < target) random_blit_phase();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_rectangle();
		test_load_extremes();
		test_raster_order();
		test_frame_edges();
		test_rectangle_shrink();
		test_register_masking();
		test_largest_rectangle();
		test_random_blits(16, 74, 380);
		test_random_blits(74, 16, 380);
		test_random_blits(0, 0, 390);
		drain();
		if (failures == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#8_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule
